// ----- sv/bbfs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbfs_pkg: shared types and constants of the bus byte frame segmenter
// Holds the action, result kind and cut reason codes, the configuration
// register indexes with their reset values, and the result word layout.
// ----------------------------------------------------------------------------
package bbfs_pkg;

  // Input actions.
  localparam logic [1:0] ACT_BEGIN  = 2'd0;
  localparam logic [1:0] ACT_BYTE   = 2'd1;
  localparam logic [1:0] ACT_POLL   = 2'd2;
  localparam logic [1:0] ACT_FINISH = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_NONE  = 2'd2;

  // Reasons a frame is cut.
  localparam logic [2:0] CUT_DIR    = 3'd0;
  localparam logic [2:0] CUT_IDLE   = 3'd1;
  localparam logic [2:0] CUT_CAP    = 3'd2;
  localparam logic [2:0] CUT_FULL   = 3'd3;
  localparam logic [2:0] CUT_WINDOW = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] REG_WINDOW_MS      = 3'd0;
  localparam logic [2:0] REG_IDLE_GAP_MS    = 3'd1;
  localparam logic [2:0] REG_FRAME_LIMIT    = 3'd2;
  localparam logic [2:0] REG_FRAME_BYTE_CAP = 3'd3;
  localparam logic [2:0] REG_BYTE_BUDGET    = 3'd4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Configuration reset values.
  localparam logic [31:0] WINDOW_MS_RST      = 32'd30000;
  localparam logic [15:0] IDLE_GAP_MS_RST    = 16'd5;
  localparam logic [15:0] FRAME_LIMIT_RST    = 16'd256;
  localparam logic [15:0] FRAME_BYTE_CAP_RST = 16'd256;
  localparam logic [23:0] BYTE_BUDGET_RST    = 24'd65536;

  // Most results one input word can cause.
  localparam int MAX_RES = 3;

  // Bus widths.
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 112;

  // One result word, without the per-input flags.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte_out;
    logic [15:0] frame_index;
    logic        frame_direction;
    logic [31:0] frame_offset_ms;
    logic [31:0] frame_gap_ms;
    logic [15:0] frame_length;
    logic [2:0]  cut_reason;
  } res_t;

  // All results of one input word together with its end-of-input flags.
  typedef struct packed {
    res_t [MAX_RES-1:0] res;
    logic [1:0]         cnt;
    logic               truncated;
    logic               done_res;
  } batch_t;

endpackage

// ----- sv/bbfs_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbfs_core: input register, capture state and segmenting logic
// Registers one input word, works out every result it causes together with
// the next capture state in one pass, and hands the batch on when the
// result buffer can take it. Also holds the configuration registers.
// ----------------------------------------------------------------------------
module bbfs_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_action,
  input  logic                             in_direction,
  input  logic [7:0]                       in_data_byte,
  input  logic [31:0]                      in_now_ms,
  input  logic                             cfg_we,
  input  logic [bbfs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bbfs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output logic                             batch_valid,
  input  logic                             batch_ready,
  output bbfs_pkg::batch_t                 batch
);

  typedef struct packed {
    logic [31:0] window_start;
    logic [31:0] last_byte_time;
    logic        frame_open;
    logic        open_direction;
    logic [31:0] open_offset;
    logic [31:0] open_gap;
    logic [15:0] open_length;
    logic [15:0] frames_closed;
    logic [23:0] bytes_total;
    logic        truncated_flag;
  } st_t;

  typedef struct packed {
    logic [31:0] window_ms;
    logic [15:0] idle_gap_ms;
    logic [15:0] frame_limit;
    logic [15:0] frame_byte_cap;
    logic [23:0] byte_budget;
  } cfg_t;

  cfg_t        cfg_r;
  st_t         st_r;
  st_t         st_nxt;
  bbfs_pkg::batch_t bat;
  logic        vld_r;
  logic [1:0]  act_r;
  logic        dir_r;
  logic [7:0]  byte_r;
  logic [31:0] now_r;
  logic        commit;
  logic        elapsed;

  // Append one result while there is room; later ones are dropped.
  function automatic void put_result(inout bbfs_pkg::batch_t b, input bbfs_pkg::res_t r);
    if (b.cnt != 2'd3) begin
      b.res[b.cnt] = r;
      b.cnt = b.cnt + 2'd1;
    end
  endfunction

  function automatic void close_frame(inout st_t s, inout bbfs_pkg::batch_t b,
                                      input logic [2:0] reason);
    bbfs_pkg::res_t r;
    if (s.frame_open) begin
      r = '0;
      r.kind            = bbfs_pkg::KIND_CLOSE;
      r.frame_index     = s.frames_closed;
      r.frame_direction = s.open_direction;
      r.frame_offset_ms = s.open_offset;
      r.frame_gap_ms    = s.open_gap;
      r.frame_length    = s.open_length;
      r.cut_reason      = reason;
      put_result(b, r);
      if (s.frames_closed != 16'hFFFF) s.frames_closed = s.frames_closed + 16'd1;
      s.frame_open  = 1'b0;
      s.open_length = 16'd0;
    end
  endfunction

  function automatic void open_frame(inout st_t s, input logic dir,
                                     input logic [31:0] now, input logic [31:0] gap);
    s.frame_open     = 1'b1;
    s.open_direction = dir;
    s.open_offset    = now - s.window_start;
    s.open_gap       = gap;
    s.open_length    = 16'd0;
  endfunction

  function automatic void feed_byte(inout st_t s, inout bbfs_pkg::batch_t b,
                                    input logic dir, input logic [7:0] db,
                                    input logic [31:0] now, input cfg_t c);
    logic           stop;
    bbfs_pkg::res_t r;
    stop = 1'b0;
    // Direction change is checked before the idle gap.
    if (s.frame_open) begin
      if (s.open_direction != dir) close_frame(s, b, bbfs_pkg::CUT_DIR);
      else if ((now - s.last_byte_time) >= {16'd0, c.idle_gap_ms})
        close_frame(s, b, bbfs_pkg::CUT_IDLE);
    end
    // No room left: refuse the byte.
    if (s.frames_closed >= c.frame_limit || s.bytes_total >= c.byte_budget) begin
      s.truncated_flag = 1'b1;
      stop = 1'b1;
    end
    if (!stop) begin
      if (!s.frame_open) open_frame(s, dir, now, now - s.last_byte_time);
      if (s.open_length >= c.frame_byte_cap) begin
        close_frame(s, b, bbfs_pkg::CUT_CAP);
        if (s.frames_closed >= c.frame_limit) begin
          s.truncated_flag = 1'b1;
          stop = 1'b1;
        end else begin
          open_frame(s, dir, now, 32'd0);
        end
      end
    end
    // Store the byte.
    if (!stop) begin
      if (s.open_length != 16'hFFFF) s.open_length = s.open_length + 16'd1;
      s.bytes_total = s.bytes_total + 24'd1;
      r = '0;
      r.kind            = bbfs_pkg::KIND_BYTE;
      r.data_byte_out   = db;
      r.frame_index     = s.frames_closed;
      r.frame_direction = s.open_direction;
      r.frame_offset_ms = s.open_offset;
      r.frame_gap_ms    = s.open_gap;
      r.frame_length    = s.open_length;
      put_result(b, r);
      s.last_byte_time = now;
      if (s.bytes_total >= c.byte_budget) begin
        s.truncated_flag = 1'b1;
        close_frame(s, b, bbfs_pkg::CUT_FULL);
      end
    end
  endfunction

  // The held word moves on when the result buffer takes its batch.
  assign commit      = vld_r && batch_ready;
  assign in_ready    = !vld_r || batch_ready;
  assign batch_valid = vld_r;
  assign batch       = bat;

  // Segmenting pass for the held word.
  always_comb begin
    st_nxt = st_r;
    bat    = '0;
    case (act_r)
      bbfs_pkg::ACT_BEGIN: begin
        st_nxt.window_start   = now_r;
        st_nxt.last_byte_time = now_r;
      end
      bbfs_pkg::ACT_FINISH: begin
        close_frame(st_nxt, bat, bbfs_pkg::CUT_WINDOW);
      end
      default: begin
        if ((now_r - st_r.window_start) < cfg_r.window_ms) begin
          if (act_r == bbfs_pkg::ACT_BYTE) begin
            feed_byte(st_nxt, bat, dir_r, byte_r, now_r, cfg_r);
          end else if (st_nxt.frame_open &&
                       (now_r - st_nxt.last_byte_time) >= {16'd0, cfg_r.idle_gap_ms}) begin
            close_frame(st_nxt, bat, bbfs_pkg::CUT_IDLE);
          end
        end
      end
    endcase
    // Nothing recorded: a single empty result.
    if (bat.cnt == 2'd0) begin
      bat.res[0].kind = bbfs_pkg::KIND_NONE;
      bat.cnt         = 2'd1;
    end
    elapsed = (now_r - st_nxt.window_start) >= cfg_r.window_ms;
    bat.truncated = st_nxt.truncated_flag;
    bat.done_res  = st_nxt.truncated_flag || (st_nxt.frames_closed >= cfg_r.frame_limit) ||
                    (st_nxt.bytes_total >= cfg_r.byte_budget) || elapsed;
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      vld_r <= 1'b1;
    end else if (commit) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      act_r  <= in_action;
      dir_r  <= in_direction;
      byte_r <= in_data_byte;
      now_r  <= in_now_ms;
    end
  end

  // Capture state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (commit) begin
      st_r <= st_nxt;
    end
  end

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_ms      <= bbfs_pkg::WINDOW_MS_RST;
      cfg_r.idle_gap_ms    <= bbfs_pkg::IDLE_GAP_MS_RST;
      cfg_r.frame_limit    <= bbfs_pkg::FRAME_LIMIT_RST;
      cfg_r.frame_byte_cap <= bbfs_pkg::FRAME_BYTE_CAP_RST;
      cfg_r.byte_budget    <= bbfs_pkg::BYTE_BUDGET_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bbfs_pkg::REG_WINDOW_MS:      cfg_r.window_ms      <= cfg_wdata;
        bbfs_pkg::REG_IDLE_GAP_MS:    cfg_r.idle_gap_ms    <= cfg_wdata[15:0];
        bbfs_pkg::REG_FRAME_LIMIT:    cfg_r.frame_limit    <= cfg_wdata[15:0];
        bbfs_pkg::REG_FRAME_BYTE_CAP: cfg_r.frame_byte_cap <= cfg_wdata[15:0];
        bbfs_pkg::REG_BYTE_BUDGET:    cfg_r.byte_budget    <= cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- sv/bbfs_out.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbfs_out: result buffer
// Holds the up to three results of one input word and sends one word a cycle
// unless stalled, front slot first. A new batch loads as the last word leaves.
// ----------------------------------------------------------------------------
module bbfs_out (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             batch_valid,
  output logic             batch_ready,
  input  bbfs_pkg::batch_t batch,
  output logic             out_valid,
  input  logic             out_ready,
  output bbfs_pkg::res_t   out_res,
  output logic             out_truncated,
  output logic             out_done_res,
  output logic             out_last
);

  bbfs_pkg::res_t res_r [bbfs_pkg::MAX_RES];
  logic [1:0]     rem_r;
  logic           trunc_r;
  logic           done_r;
  logic           take;
  logic           load;

  assign out_valid     = rem_r != 2'd0;
  assign take          = out_valid && out_ready;
  assign batch_ready   = (rem_r == 2'd0) || (rem_r == 2'd1 && take);
  assign load          = batch_valid && batch_ready;
  assign out_res       = res_r[0];
  assign out_truncated = trunc_r;
  assign out_done_res  = done_r;
  assign out_last      = rem_r == 2'd1;

  // Count of words still to send.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 2'd0;
    end else if (load) begin
      rem_r <= batch.cnt;
    end else if (take) begin
      rem_r <= rem_r - 2'd1;
    end
  end

  // Result slots: load a batch or shift toward the front slot.
  always_ff @(posedge clk) begin
    if (load) begin
      res_r[0] <= batch.res[0];
      res_r[1] <= batch.res[1];
      res_r[2] <= batch.res[2];
      trunc_r  <= batch.truncated;
      done_r   <= batch.done_res;
    end else if (take) begin
      res_r[0] <= res_r[1];
      res_r[1] <= res_r[2];
    end
  end

endmodule

// ----- sv/bus_byte_frame_segmenter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bus_byte_frame_segmenter: cuts a timestamped bus byte stream into frames
// Each input word is one action (begin window, byte, empty poll, finish);
// each causes one to three result words: stored bytes and closed frames.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on in_* (tuser carries the action), results leave on
//   out_* (tuser carries the result kind, tlast marks the final result of
//   one input word). Configuration is written through cfg_we/cfg_index/
//   cfg_wdata while the block is idle; it takes effect on the next word.
//   The first result of a word is worked out from the input register and
//   registered in the result buffer before it appears on out_*. The block
//   takes one input word per cycle while each causes one result and the
//   receiver takes every result word; a word with several results holds
//   the output until each has left, so the worst case is set by the single
//   output port draining the three-slot result buffer.
//   The input register and the result buffer are separate stages, so a new
//   word is taken while earlier results still wait on the output.
//   Reset clears all capture state and counters and loads the register
//   defaults. When the receiver stalls, the result word holds, the buffer
//   fills, and in_tready drops until the buffer can load again.
// ----------------------------------------------------------------------------
module bus_byte_frame_segmenter (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: direction[0], data_byte[8:1], now_ms[40:9], zero pad[47:41]
  input  logic [bbfs_pkg::IN_DATA_W-1:0]   in_tdata,
  // in_tuser: action[1:0]
  input  logic [1:0]                       in_tuser,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // out_tdata: data_byte_out[7:0], frame_index[23:8], frame_direction[24],
  //   frame_offset_ms[56:25], frame_gap_ms[88:57], frame_length[104:89],
  //   cut_reason[107:105], truncated[108], done_res[109], zero pad[111:110]
  output logic [bbfs_pkg::OUT_DATA_W-1:0]  out_tdata,
  // out_tuser: kind[1:0]
  output logic [1:0]                       out_tuser,
  output logic                             out_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_we,
  input  logic [bbfs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bbfs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  logic             batch_valid;
  logic             batch_ready;
  bbfs_pkg::batch_t batch;
  bbfs_pkg::res_t   res;
  logic             res_trunc;
  logic             res_done;

  // Segmenting stage.
  bbfs_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_action    (in_tuser),
    .in_direction (in_tdata[0]),
    .in_data_byte (in_tdata[8:1]),
    .in_now_ms    (in_tdata[40:9]),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .batch_valid  (batch_valid),
    .batch_ready  (batch_ready),
    .batch        (batch)
  );

  // Result buffer.
  bbfs_out u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .batch_valid   (batch_valid),
    .batch_ready   (batch_ready),
    .batch         (batch),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_res       (res),
    .out_truncated (res_trunc),
    .out_done_res  (res_done),
    .out_last      (out_tlast)
  );

  // Pack the result word.
  assign out_tuser = res.kind;
  assign out_tdata = {2'b00, res_done, res_trunc, res.cut_reason, res.frame_length,
                      res.frame_gap_ms, res.frame_offset_ms, res.frame_direction,
                      res.frame_index, res.data_byte_out};

endmodule

// ----- sv/bbfs_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbfs_chk: port checker for the bus byte frame segmenter
// Watches the top-level ports for result ordering and field consistency,
// and is bound to every instance of the top level.
// ----------------------------------------------------------------------------
module bbfs_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic [bbfs_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic [1:0]                       out_tuser,
  input logic                             out_tlast,
  input logic                             out_tvalid,
  input logic                             out_tready
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
                                  && $stable(out_tlast))
    else $error("result word changed while stalled");

  // No results come out right after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result word shown right after reset");

  // An empty result is always the last result of its input.
  a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == bbfs_pkg::KIND_NONE |-> out_tlast)
    else $error("empty result not last of its input");

  // A cut reason only travels with a closed frame.
  a_reason_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != bbfs_pkg::KIND_CLOSE |-> out_tdata[107:105] == 3'd0)
    else $error("cut reason on a result that closes no frame");

  // Within one input the flags stay the same from word to word.
  a_flags_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid &&
      out_tdata[109:108] == $past(out_tdata[109:108]))
    else $error("truncated or done flag changed within one input");

endmodule

bind bus_byte_frame_segmenter bbfs_chk u_chk (.*);
